FILE: rtl/bsc_pkg.sv
// shared types and constants for the braking step count unit
`default_nettype none
package bsc_pkg;
   localparam int PERIOD_BITS = 24;
   localparam int VALUE_BITS  = 32;
   localparam int COUNT_BITS  = 20;
   localparam int MAG_BITS    = VALUE_BITS + 1;
   localparam int BND_BITS    = VALUE_BITS;
   localparam int PSQ_BITS    = 2 * PERIOD_BITS;
   localparam int HALF_BITS   = PERIOD_BITS;
   localparam int PROD_BITS   = HALF_BITS + BND_BITS;
   localparam int K_BITS      = PSQ_BITS + BND_BITS - 1;
   localparam int R_SHIFT     = 2 * PERIOD_BITS + 1;
   localparam int R_BITS      = MAG_BITS + R_SHIFT;
   localparam int T_BITS      = K_BITS + COUNT_BITS;
   localparam int WIDE_BITS   = T_BITS + COUNT_BITS + 3;
   localparam int BIT_SEL_BITS = $clog2(COUNT_BITS);
   localparam int ADDR_BITS   = 3;
   localparam int DATA_BITS   = 32;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(16777);
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0]  COUNT_ONE    = COUNT_BITS'(1);
   localparam logic [0:0]             REG_PERIOD   = 1'b0;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] limit_value;
      logic signed [VALUE_BITS-1:0] current_value;
      logic signed [VALUE_BITS-1:0] rate_bound;
   } req_data_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] step_count;
      logic                  bad_sign;
      logic                  saturated;
   } rsp_data_type;

   // one item in flight through the root search
   typedef struct packed {
      logic                   valid;
      logic                   bad;
      logic                   zero;
      logic [K_BITS-1:0]      k;
      logic [R_BITS-1:0]      r;
      logic [R_BITS-1:0]      s;
      logic [T_BITS-1:0]      t;
      logic [COUNT_BITS-1:0]  m;
   } search_type;
endpackage
`default_nettype wire

FILE: rtl/bsc_front.sv
// front stages: sign checks, magnitudes and the period squared times bound product
`default_nettype none
module bsc_front import bsc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire req_data_type           in_data,
   input  wire logic [PERIOD_BITS-1:0] period,
   output search_type                  out_item
);
   logic signed [MAG_BITS-1:0] gap;
   logic signed [MAG_BITS-1:0] bnd;
   logic bad_in;

   logic v1_ff, bad1_ff, zero1_ff;
   logic [MAG_BITS-1:0] g1_ff;
   logic [BND_BITS-1:0] b1_ff;
   logic [PSQ_BITS-1:0] psq1_ff;

   logic v2_ff, bad2_ff, zero2_ff;
   logic [MAG_BITS-1:0] g2_ff;
   logic [PROD_BITS-1:0] plo2_ff, phi2_ff;

   logic v3_ff, bad3_ff, zero3_ff;
   logic [MAG_BITS-1:0] g3_ff;
   logic [K_BITS-1:0] k3_ff;

   // gap and sign test
   always_comb begin
      gap = MAG_BITS'(in_data.limit_value) - MAG_BITS'(in_data.current_value);
      bnd = MAG_BITS'(in_data.rate_bound);
      bad_in = (bnd == '0) || (gap > 0 && bnd > 0) || (gap < 0 && bnd < 0);
   end

   // stage one: magnitudes and period squared
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
      if (advance) begin
         bad1_ff <= bad_in;
         zero1_ff <= (gap == '0);
         g1_ff <= gap[MAG_BITS-1] ? MAG_BITS'(-gap) : MAG_BITS'(gap);
         b1_ff <= bnd[MAG_BITS-1] ? BND_BITS'(-bnd) : BND_BITS'(bnd);
         psq1_ff <= PSQ_BITS'(period) * PSQ_BITS'(period);
      end
   end

   // stage two: two partial products of period squared by bound
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         bad2_ff <= bad1_ff;
         zero2_ff <= zero1_ff;
         g2_ff <= g1_ff;
         plo2_ff <= PROD_BITS'(psq1_ff[HALF_BITS-1:0]) * PROD_BITS'(b1_ff);
         phi2_ff <= PROD_BITS'(psq1_ff[PSQ_BITS-1:HALF_BITS]) * PROD_BITS'(b1_ff);
      end
   end

   // stage three: combine partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         bad3_ff <= bad2_ff;
         zero3_ff <= zero2_ff;
         g3_ff <= g2_ff;
         k3_ff <= K_BITS'(plo2_ff) + (K_BITS'(phi2_ff) << HALF_BITS);
      end
   end

   always_comb begin
      out_item.valid = v3_ff;
      out_item.bad   = bad3_ff;
      out_item.zero  = zero3_ff;
      out_item.k     = k3_ff;
      out_item.r     = R_BITS'(g3_ff) << R_SHIFT;
      out_item.s     = '0;
      out_item.t     = '0;
      out_item.m     = '0;
   end
endmodule
`default_nettype wire

FILE: rtl/bsc_root_stage.sv
// one bit of the integer root search: tries setting one bit of the count
`default_nettype none
module bsc_root_stage import bsc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic [BIT_SEL_BITS-1:0] bit_sel,
   input  wire search_type              in_item,
   output search_type                   out_item
);
   logic [WIDE_BITS-1:0] cand;
   logic take;
   search_type item_in, item_ff;

   // candidate (m + 2^i)^2 * k from running m^2*k and m*k
   always_comb begin
      cand = WIDE_BITS'(in_item.s)
           + (WIDE_BITS'(in_item.t) << (bit_sel + BIT_SEL_BITS'(1)))
           + (WIDE_BITS'(in_item.k) << {bit_sel, 1'b0});
      take = cand < WIDE_BITS'(in_item.r);
      item_in = in_item;
      if (take) begin
         item_in.s = R_BITS'(cand);
         item_in.t = in_item.t + (T_BITS'(in_item.k) << bit_sel);
         item_in.m = in_item.m | (COUNT_ONE << bit_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff.valid <= item_in.valid;
      end
      if (advance) begin
         item_ff.bad  <= item_in.bad;
         item_ff.zero <= item_in.zero;
         item_ff.k    <= item_in.k;
         item_ff.r    <= item_in.r;
         item_ff.s    <= item_in.s;
         item_ff.t    <= item_in.t;
         item_ff.m    <= item_in.m;
      end
   end

   assign out_item = item_ff;
endmodule
`default_nettype wire

FILE: rtl/braking_step_count_unit.sv
// Braking step count unit: periods needed to stop under a constant opposing bound.
// Returns the smallest n >= 1 with n*n*dt*dt*|bound| >= 2*|limit-current|, with flags for a
// bad sign (or zero bound) and for saturation at 1048575. One transfer is taken every cycle while
// no result is held. Each result passes through three front stages that form period squared
// times bound, then twenty stages settle one bit of the count each, then one output stage.
// The whole pipeline holds while a result waits on rsp_stall. The period register sits at
// byte address 0 of the csr port and resets to 16777 (about 1 ms in Q0.24).
`default_nettype none
module braking_step_count_unit import bsc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_data_type         req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_data_type              rsp_data,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [ADDR_BITS-1:0] csr_paddr,
   input  wire logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0]      csr_prdata,
   output logic                      csr_pready
);
   logic [PERIOD_BITS-1:0] period_ff;
   logic advance;
   search_type chain [COUNT_BITS+1];
   logic rsp_valid_ff;
   rsp_data_type rsp_data_ff, rsp_data_in;

   // period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[ADDR_BITS-1] == REG_PERIOD) begin
         period_ff <= csr_pwdata[PERIOD_BITS-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[ADDR_BITS-1] == REG_PERIOD) ?
                       DATA_BITS'(period_ff) : '0;

   // pipeline moves unless the result is held
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   bsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_data  (req_data),
      .period   (period_ff),
      .out_item (chain[0])
   );

   // root search, most significant bit first
   for (genvar i = 0; i < COUNT_BITS; i++) begin : g_root
      bsc_root_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .bit_sel  (BIT_SEL_BITS'(COUNT_BITS - 1 - i)),
         .in_item  (chain[i]),
         .out_item (chain[i+1])
      );
   end

   // final count: one past the largest m that still falls short
   always_comb begin
      rsp_data_in.bad_sign   = chain[COUNT_BITS].bad;
      rsp_data_in.saturated  = 1'b0;
      rsp_data_in.step_count = COUNT_ONE;
      if (!chain[COUNT_BITS].bad && !chain[COUNT_BITS].zero) begin
         if (chain[COUNT_BITS].m == COUNT_MAX) begin
            rsp_data_in.saturated  = 1'b1;
            rsp_data_in.step_count = COUNT_MAX;
         end else begin
            rsp_data_in.step_count = chain[COUNT_BITS].m + COUNT_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain[COUNT_BITS].valid;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire

FILE: rtl/bsc_checker.sv
// port-level checks for the braking step count unit
`default_nettype none
module bsc_checker import bsc_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_data_type rsp_data
);
   // held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input side only waits on a held result
   a_no_extra_stall: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled without a held result");

   // bad sign gives a count of one
   a_bad_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_sign |->
         rsp_data.step_count == COUNT_ONE && !rsp_data.saturated)
      else $error("bad sign result malformed");

   // saturation pins the count at its maximum
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.step_count == COUNT_MAX)
      else $error("saturated count not at maximum");

   // count is never zero
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.step_count != '0)
      else $error("zero step count");
endmodule

bind braking_step_count_unit bsc_checker u_bsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
